// ===== hdl/ffd_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer package
// Shared constants, status codes and the result word type.
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam logic [7:0] HEADER_RESET = 8'h81;
  localparam logic [7:0] FOOTER_RESET = 8'h88;

  localparam int         PAYLOAD_LEN  = 8;
  localparam int         PAY_IDX_W    = $clog2(PAYLOAD_LEN);
  localparam logic [3:0] POS_IDLE     = 4'd0;
  localparam logic [3:0] POS_LAST     = 4'd9;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_FOOTER = 1'b1;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_BAD_HEAD = 2'd2,
    ST_BAD_FOOT = 2'd3
  } status_t;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    status_t     status;
    byte_t [7:0] payload;
    logic [15:0] bad_frames;
  } result_t;

endpackage

// ===== hdl/ffd_if.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer channels
// Valid/ready interfaces for the byte input and the status result.
// ----------------------------------------------------------------------------
interface ffd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  dest;
  logic [7:0]  kind;
  logic [7:0]  seq_high;
  logic [7:0]  seq_low;
  logic [7:0]  data_a;
  logic [7:0]  data_b;
  logic [7:0]  data_c;
  logic [7:0]  data_d;
  logic [15:0] bad_frames;

  modport source (
    output valid, output status, output dest, output kind, output seq_high,
    output seq_low, output data_a, output data_b, output data_c, output data_d,
    output bad_frames, input ready
  );
  modport sink (
    input valid, input status, input dest, input kind, input seq_high,
    input seq_low, input data_a, input data_b, input data_c, input data_d,
    input bad_frames, output ready
  );
endinterface

// ===== hdl/fixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer
// Finds 10-byte frames (header, 8 payload bytes, footer) in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per word. out_ch returns exactly one
//   status word per input byte: in progress, frame complete with the eight
//   payload bytes, bad header dropped, or bad footer, plus the saturating
//   count of invalid headers and footers.
//   cfg_we/cfg_index/cfg_data write the header value (index 0) and the
//   footer value (index 1); write them only while the block is idle.
//   Latency: the status word for a byte is valid the cycle after the byte
//   is accepted. Throughput: one byte per cycle when not stalled, set by the
//   single result register that follows the position and count update.
//   Reset: position returns to waiting for a header, the count clears,
//   header and footer return to 0x81 and 0x88, no result is pending.
//   Stall: while out_ch.ready is low with a word pending, in_ch.ready drops
//   and the pending word holds; a byte is taken in the same cycle that the
//   pending word leaves.
// ----------------------------------------------------------------------------
module fixed_frame_deframer (
  input  logic         clk,
  input  logic         rst_n,
  ffd_in_if.sink       in_ch,
  ffd_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);

  logic             take;
  logic             can_load;
  ffd_pkg::result_t result;
  ffd_pkg::result_t held;

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;

  ffd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .rx_byte   (in_ch.rx_byte),
    .result    (result)
  );

  ffd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .result    (result),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_load  (can_load),
    .held      (held)
  );

  assign out_ch.status     = held.status;
  assign out_ch.dest       = held.payload[0];
  assign out_ch.kind       = held.payload[1];
  assign out_ch.seq_high   = held.payload[2];
  assign out_ch.seq_low    = held.payload[3];
  assign out_ch.data_a     = held.payload[4];
  assign out_ch.data_b     = held.payload[5];
  assign out_ch.data_c     = held.payload[6];
  assign out_ch.data_d     = held.payload[7];
  assign out_ch.bad_frames = held.bad_frames;

endmodule

// ===== hdl/ffd_core.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer core
// Frame position, payload capture, invalid count and result formation.
// ----------------------------------------------------------------------------
module ffd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  output ffd_pkg::result_t result
);

  logic [7:0]         header_r;
  logic [7:0]         footer_r;
  logic [3:0]         pos_r;
  logic [3:0]         pos_nxt;
  logic [15:0]        count_r;
  logic [15:0]        count_nxt;
  ffd_pkg::byte_t [7:0] pay_r;
  logic               pay_we;
  logic [ffd_pkg::PAY_IDX_W-1:0] pay_idx;
  logic [3:0]         pos_m1;
  logic               bump;
  ffd_pkg::status_t   status;

  assign pos_m1  = pos_r - 4'd1;
  assign pay_idx = pos_m1[ffd_pkg::PAY_IDX_W-1:0];

  always_comb begin
    pos_nxt = pos_r;
    status  = ffd_pkg::ST_BUSY;
    bump    = 1'b0;
    pay_we  = 1'b0;
    if (pos_r == ffd_pkg::POS_IDLE || pos_r > ffd_pkg::POS_LAST) begin
      if (rx_byte == header_r) begin
        pos_nxt = 4'd1;
      end else begin
        pos_nxt = ffd_pkg::POS_IDLE;
        bump    = 1'b1;
        status  = ffd_pkg::ST_BAD_HEAD;
      end
    end else if (pos_r < ffd_pkg::POS_LAST) begin
      pay_we  = 1'b1;
      pos_nxt = pos_r + 4'd1;
    end else begin
      pos_nxt = ffd_pkg::POS_IDLE;
      if (rx_byte == footer_r) begin
        status = ffd_pkg::ST_DONE;
      end else begin
        bump   = 1'b1;
        status = ffd_pkg::ST_BAD_FOOT;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (bump && count_r != 16'hFFFF) begin
      count_nxt = count_r + 16'd1;
    end
  end

  always_comb begin
    result.status     = status;
    result.payload    = (status == ffd_pkg::ST_DONE) ? pay_r : '0;
    result.bad_frames = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= ffd_pkg::HEADER_RESET;
      footer_r <= ffd_pkg::FOOTER_RESET;
      pos_r    <= ffd_pkg::POS_IDLE;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ffd_pkg::CFG_HEADER: header_r <= cfg_data;
          ffd_pkg::CFG_FOOTER: footer_r <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        pos_r   <= pos_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pay_we) begin
      pay_r[pay_idx] <= rx_byte;
    end
  end

endmodule

// ===== hdl/ffd_out_reg.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ffd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ffd_pkg::result_t  result,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_load,
  output ffd_pkg::result_t  held
);

  logic             valid_r;
  ffd_pkg::result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// ===== hdl/ffd_checker.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ffd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] fields,
  input logic [15:0] bad_frames
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte gave no result word");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ffd_pkg::ST_DONE |-> fields == '0)
    else $error("payload fields nonzero without frame complete");

  a_bad_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ffd_pkg::ST_BAD_HEAD || status == ffd_pkg::ST_BAD_FOOT)
      |-> bad_frames != 16'd0)
    else $error("invalid status with zero count");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind fixed_frame_deframer ffd_checker u_ffd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .fields     ({out_ch.dest, out_ch.kind, out_ch.seq_high, out_ch.seq_low,
                out_ch.data_a, out_ch.data_b, out_ch.data_c, out_ch.data_d}),
  .bad_frames (out_ch.bad_frames)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Fixed frame deframer testbench
// Drives byte streams through the deframer and checks every status word
// against a cycle-free prediction of the frame position, captured payload
// and saturating invalid count. The stream opens with hand-picked frames,
// then random frames, noise and broken frames under several header and
// footer settings, and ends with a run of bad bytes and two frames at full rate.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASE_BYTES    = 140;
  localparam int TAIL_BYTES     = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we = 1'b0;
  logic           cfg_index = ffd_pkg::CFG_HEADER;
  ffd_pkg::byte_t cfg_data = '0;

  ffd_in_if  in_ch ();
  ffd_out_if out_ch ();

  fixed_frame_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted deframer state
  ffd_pkg::byte_t       head_cfg = ffd_pkg::HEADER_RESET;
  ffd_pkg::byte_t       foot_cfg = ffd_pkg::FOOTER_RESET;
  logic [3:0]           frame_pos = ffd_pkg::POS_IDLE;
  ffd_pkg::byte_t [7:0] held_payload = '0;
  logic [15:0]          bad_count = '0;

  ffd_pkg::byte_t   byte_q[$];
  ffd_pkg::result_t status_q[$];

  int n_sent = 0;
  int n_taken = 0;
  int n_words = 0;
  int n_errors = 0;
  int n_done = 0;
  int n_bad_head = 0;
  int n_bad_foot = 0;
  int n_settings = 1;
  int quiet_cycles = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;
  bit idle_on = 1'b1;

  string field_name [8] = '{"dest", "kind", "seq_high", "seq_low",
                            "data_a", "data_b", "data_c", "data_d"};

  function automatic void deframe_byte(input ffd_pkg::byte_t b);
    ffd_pkg::result_t                r;
    bit                              invalid;
    logic [3:0]                      pos_m1;
    logic [ffd_pkg::PAY_IDX_W-1:0]   slot;
    r = '0;
    r.status = ffd_pkg::ST_BUSY;
    invalid = 1'b0;
    if (frame_pos == ffd_pkg::POS_IDLE || frame_pos > ffd_pkg::POS_LAST) begin
      if (b == head_cfg) begin
        frame_pos = 4'd1;
      end else begin
        frame_pos = ffd_pkg::POS_IDLE;
        invalid = 1'b1;
        r.status = ffd_pkg::ST_BAD_HEAD;
      end
    end else if (frame_pos < ffd_pkg::POS_LAST) begin
      pos_m1 = frame_pos - 4'd1;
      slot = pos_m1[ffd_pkg::PAY_IDX_W-1:0];
      held_payload[slot] = b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_pos = ffd_pkg::POS_IDLE;
      if (b == foot_cfg) begin
        r.status = ffd_pkg::ST_DONE;
        r.payload = held_payload;
      end else begin
        invalid = 1'b1;
        r.status = ffd_pkg::ST_BAD_FOOT;
      end
    end
    if (invalid && bad_count != 16'hFFFF)
      bad_count = bad_count + 16'd1;
    r.bad_frames = bad_count;
    status_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.rx_byte);
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (idle_on && in_calm == 0 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
          in_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          if (in_calm > 0)
            in_calm--;
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= byte_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ffd_pkg::result_t want;
    ffd_pkg::result_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_words++;
        got.status = ffd_pkg::status_t'(out_ch.status);
        got.payload = {out_ch.data_d, out_ch.data_c, out_ch.data_b, out_ch.data_a,
                       out_ch.seq_low, out_ch.seq_high, out_ch.kind, out_ch.dest};
        got.bad_frames = out_ch.bad_frames;
        case (got.status)
          ffd_pkg::ST_DONE:     n_done++;
          ffd_pkg::ST_BAD_HEAD: n_bad_head++;
          ffd_pkg::ST_BAD_FOOT: n_bad_foot++;
          default:              ;
        endcase
        if (status_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("word %0d: status word with none expected, status %0d count %0d",
                     n_words, got.status, got.bad_frames);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
              if (got.status !== want.status)
                $display("word %0d: status expected %0d got %0d",
                         n_words, want.status, got.status);
              for (int i = 0; i < ffd_pkg::PAYLOAD_LEN; i++)
                if (got.payload[i] !== want.payload[i])
                  $display("word %0d: %s expected %02h got %02h",
                           n_words, field_name[i], want.payload[i], got.payload[i]);
              if (got.bad_frames !== want.bad_frames)
                $display("word %0d: bad_frames expected %0d got %0d",
                         n_words, want.bad_frames, got.bad_frames);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && out_calm == 0 && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_calm = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
        out_ch.ready <= 1'b0;
      end else begin
        if (out_calm > 0)
          out_calm--;
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles, %0d words outstanding",
                 quiet_cycles, status_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(input ffd_pkg::byte_t b);
    byte_q.push_back(b);
    n_sent++;
  endtask

  task automatic send_frame(input ffd_pkg::byte_t head, input ffd_pkg::byte_t [7:0] fill,
                            input ffd_pkg::byte_t tail);
    send_byte(head);
    for (int i = 0; i < ffd_pkg::PAYLOAD_LEN; i++)
      send_byte(fill[i]);
    send_byte(tail);
  endtask

  task automatic drain_words();
    while (n_taken != n_sent || status_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input ffd_pkg::byte_t value);
    if (idx == ffd_pkg::CFG_HEADER)
      head_cfg = value;
    else
      foot_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input ffd_pkg::byte_t head, input ffd_pkg::byte_t tail,
                           input int n_bytes);
    int                   start;
    int                   pick;
    ffd_pkg::byte_t [7:0] fill;
    drain_words();
    write_reg(ffd_pkg::CFG_HEADER, head);
    write_reg(ffd_pkg::CFG_FOOTER, tail);
    n_settings++;
    start = n_sent;
    while (n_sent - start < n_bytes) begin
      pick = $urandom_range(0, 9);
      fill = {$urandom, $urandom};
      if (pick < 7) begin
        send_frame(head, fill, tail);
      end else if (pick == 7) begin
        send_frame(head, fill, tail ^ ffd_pkg::byte_t'($urandom_range(1, 255)));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) send_byte(ffd_pkg::byte_t'($urandom));
      end else begin
        send_byte(head);
        repeat ($urandom_range(1, 7)) send_byte(ffd_pkg::byte_t'($urandom));
      end
    end
  endtask

  initial begin
    ffd_pkg::byte_t [7:0] fill;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: good frame with extreme payload, bad headers, bad footer
    send_frame(ffd_pkg::HEADER_RESET,
               {8'hFE, 8'h7F, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h00},
               ffd_pkg::FOOTER_RESET);
    send_byte(8'h00);
    send_byte(8'hFF);
    // footer slot holds a header value: not taken as a new frame
    send_frame(ffd_pkg::HEADER_RESET,
               {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
               ffd_pkg::HEADER_RESET);
    send_byte(ffd_pkg::FOOTER_RESET);

    run_phase(8'h00, 8'hFF, PHASE_BYTES);
    run_phase(8'hFF, 8'h00, PHASE_BYTES);
    run_phase(ffd_pkg::byte_t'($urandom), ffd_pkg::byte_t'($urandom), PHASE_BYTES);
    run_phase(8'h5A, 8'h5A, PHASE_BYTES);
    run_phase(ffd_pkg::HEADER_RESET, ffd_pkg::FOOTER_RESET, PHASE_BYTES);

    // run of bad bytes at full rate, then a good frame and a bad footer frame
    drain_words();
    idle_on = 1'b0;
    write_reg(ffd_pkg::CFG_HEADER, 8'h00);
    n_settings++;
    repeat (TAIL_BYTES) send_byte(ffd_pkg::byte_t'($urandom_range(1, 255)));
    fill = {$urandom, $urandom};
    send_frame(8'h00, fill, ffd_pkg::FOOTER_RESET);
    send_frame(8'h00, fill, ~ffd_pkg::FOOTER_RESET);
    drain_words();
    repeat (4) @(posedge clk);

    if (status_q.size() != 0) begin
      n_errors += status_q.size();
      $display("%0d expected status words never arrived", status_q.size());
    end
    $display("Ran %0d bytes over %0d header/footer settings: %0d frames,",
             n_taken, n_settings, n_done);
    $display("%0d bad headers, %0d bad footers, invalid count finished at %0d",
             n_bad_head, n_bad_foot, bad_count);
    if (n_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
